[rtl/ssbm_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the sorted sample buffer with median readout
// no dependencies; used by ssbm_cell and sorted_sample_buffer_median
package ssbm_pkg;

   localparam int DATA_W        = 32;
   localparam int CFG_W         = 5;
   localparam int COUNT_OUT_W   = 5;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_CLEAR  = 1'b1
   } opcode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // what one cell hands to its right-hand neighbor
   typedef struct packed {
      logic                     moves;
      logic signed [DATA_W-1:0] value;
   } link_type;

endpackage

[rtl/ssbm_cell.sv]
`timescale 1ns / 1ps
// one compare-and-shift slot of the sorted chain
// depends on ssbm_pkg
module ssbm_cell (
   input  logic                              clock,
   input  logic                              load,
   input  logic                              filled,
   input  logic signed [ssbm_pkg::DATA_W-1:0] sample,
   input  ssbm_pkg::link_type                left,
   output ssbm_pkg::link_type                right
);

   logic signed [ssbm_pkg::DATA_W-1:0] value_ff;
   logic signed [ssbm_pkg::DATA_W-1:0] value_in;
   logic                               moves;

   // an empty slot counts as larger than any sample
   assign moves = !filled || (value_ff > sample);

   always_comb begin
      value_in = value_ff;
      if (load && moves) begin
         value_in = left.moves ? left.value : sample;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign right.moves = moves;
   assign right.value = value_ff;

endmodule

[rtl/sorted_sample_buffer_median.sv]
`timescale 1ns / 1ps
// sorted sample buffer: chain of compare-and-shift cells with median and max readout
// depends on ssbm_pkg and ssbm_cell
//
//  channel | ports                              | carries
//  --------+------------------------------------+-------------------------------
//  req     | req_valid/req_ready                | opcode, sample
//  rsp     | rsp_valid/rsp_ready                | median, valid, largest, count, dropped
//  csr     | csr_valid/csr_ready                | median_count write data
//
// each item passes through two steps: the sample is shifted into the cell chain,
// then the largest and median entries are picked from the updated chain into the
// result register. the next item is taken once that result register is free
// or is being emptied in the same cycle. reset clears the fill count, the
// median_count register and the handshake state; cell contents are not reset.
// csr writes are taken in any cycle.
module sorted_sample_buffer_median #(
   parameter int DEPTH = ssbm_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic signed [ssbm_pkg::DATA_W-1:0]  req_sample,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ssbm_pkg::DATA_W-1:0]  rsp_median_value,
   output logic                                rsp_median_valid,
   output logic signed [ssbm_pkg::DATA_W-1:0]  rsp_largest_value,
   output logic [ssbm_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic                                rsp_dropped,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ssbm_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > ssbm_pkg::CFG_W) ? CW : ssbm_pkg::CFG_W;

   // control state
   ssbm_pkg::state_type            state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [ssbm_pkg::CFG_W-1:0]     median_count_ff;
   logic                           dropped_ff, dropped_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // result payload
   logic signed [ssbm_pkg::DATA_W-1:0] median_ff, median_in;
   logic signed [ssbm_pkg::DATA_W-1:0] largest_ff, largest_in;
   logic [ssbm_pkg::COUNT_OUT_W-1:0]   entry_count_ff, entry_count_in;
   logic                               median_valid_ff, median_valid_in;

   // chain wiring: link[i] feeds cell i, link[i+1] comes out of it
   ssbm_pkg::link_type link [DEPTH+1];
   logic [DEPTH-1:0]   filled;

   logic accept;
   logic is_insert;
   logic discard;
   logic load;

   // median slot and readout select
   logic [CMP_W-1:0] slot_ext;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] med_idx;
   logic [CW-1:0]    top_idx;
   logic             count_nz;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         median_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         median_count_ff <= csr_wdata;
      end
   end

   assign req_ready = (state_ff == ssbm_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_insert = (req_opcode == ssbm_pkg::OP_INSERT);

   // full store and sample not below the current maximum: sample is thrown away
   assign discard = (count_ff == CW'(DEPTH)) && !link[DEPTH].moves;
   assign load    = accept && is_insert && !discard;

   // head of the chain never supplies a shifted value
   assign link[0].moves = 1'b0;
   assign link[0].value = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign filled[i] = (CW'(i) < count_ff);

      ssbm_cell u_cell (
         .clock  (clock),
         .load   (load),
         .filled (filled[i]),
         .sample (req_sample),
         .left   (link[i]),
         .right  (link[i+1])
      );
   end

   // readout indexes from the updated chain
   assign count_nz  = (count_ff != '0);
   assign top_idx   = count_ff - CW'(1);
   assign count_ext = CMP_W'(count_ff);
   assign slot_ext  = CMP_W'((ssbm_pkg::CFG_W + 1)'(median_count_ff) + 1'b1 >> 1);
   assign med_idx   = (slot_ext < count_ext) ? slot_ext : CMP_W'(top_idx);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      dropped_in      = dropped_ff;
      rsp_valid_in    = rsp_valid_ff;
      median_in       = median_ff;
      largest_in      = largest_ff;
      entry_count_in  = entry_count_ff;
      median_valid_in = median_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ssbm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ssbm_pkg::ST_READ;
               if (!is_insert) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
               end else begin
                  dropped_in = (count_ff == CW'(DEPTH));
                  if (!discard && count_ff != CW'(DEPTH)) begin
                     count_in = count_ff + CW'(1);
                  end
               end
            end
         end
         ssbm_pkg::ST_READ: begin
            // and-or select over the cells, one hit each for top and median
            median_in  = '0;
            largest_in = '0;
            for (int i = 0; i < DEPTH; i++) begin
               if (count_nz && CW'(i) == top_idx) begin
                  largest_in = largest_in | link[i+1].value;
               end
               if (count_nz && CMP_W'(i) == med_idx) begin
                  median_in = median_in | link[i+1].value;
               end
            end
            entry_count_in  = ssbm_pkg::COUNT_OUT_W'(count_ext);
            median_valid_in = count_nz;
            rsp_valid_in    = 1'b1;
            state_in        = ssbm_pkg::ST_IDLE;
         end
         default: begin
            state_in = ssbm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssbm_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dropped_ff      <= dropped_in;
      median_ff       <= median_in;
      largest_ff      <= largest_in;
      entry_count_ff  <= entry_count_in;
      median_valid_ff <= median_valid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_median_value  = median_ff;
   assign rsp_median_valid  = median_valid_ff;
   assign rsp_largest_value = largest_ff;
   assign rsp_entry_count   = entry_count_ff;
   assign rsp_dropped       = dropped_ff;

`ifndef SYNTH
   // fill count stays within the chain
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count beyond depth");

   // a clear empties the store
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == ssbm_pkg::OP_CLEAR) |=> (count_ff == '0))
      else $error("clear did not empty the store");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("item taken while another is in flight");

   // the readout cycle always leaves a result behind
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssbm_pkg::ST_READ) |=> rsp_valid_ff)
      else $error("readout produced no result");

   // an empty store reports a zero maximum
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !median_valid_ff) |-> (largest_ff == '0 && median_ff == '0))
      else $error("empty store reported nonzero values");
`endif

endmodule
